// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the enumeration engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define PBE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Checks that a condition implies a consequence in the same cycle.
`define PBE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Checks that a condition implies a consequence in the next cycle.
`define PBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/pbe_pkg.sv =====
// Types, constants and helpers shared by the enumeration engine modules.
`timescale 1ns / 1ps
package pbe_pkg;

   localparam int MAX_DEVICES_DEFAULT = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
   localparam logic [7:0]  OFF_ID = 8'h00;
   localparam logic [7:0]  OFF_HEADER = 8'h0C;
   localparam logic [3:0]  REC_LAST = 4'd9;
   localparam logic [4:0]  SLOT_LAST = 5'd31;
   localparam logic [2:0]  FUNC_LAST = 3'd7;
   localparam int          MULTI_BIT = 23;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DWORD = 2'd1,
      KIND_DONE  = 2'd2
   } pbe_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_HOST_HDR   = 3'd1,
      PH_HOST_PROBE = 3'd2,
      PH_FUNC_ID    = 3'd3,
      PH_RECORD     = 3'd4
   } pbe_phase_type;

   typedef struct packed {
      pbe_kind_type kind;
      logic [7:0]   bus_num;
      logic [4:0]   slot_num;
      logic [2:0]   func_num;
      logic [7:0]   reg_offset;
      logic [31:0]  word_value;
      logic [5:0]   device_index;
      logic         last_of_run;
   } pbe_result_type;

   // Up to two results produced by one request, in order.
   typedef struct packed {
      logic [1:0]     count;
      pbe_result_type first;
      pbe_result_type second;
   } pbe_push_type;

   // Config offsets captured for one function, by step number.
   function automatic logic [7:0] rec_offset(input logic [3:0] step);
      logic [7:0] off;
      case (step)
         4'd0:    off = 8'h00;
         4'd1:    off = 8'h08;
         4'd2:    off = 8'h0C;
         4'd3:    off = 8'h10;
         4'd4:    off = 8'h14;
         4'd5:    off = 8'h18;
         4'd6:    off = 8'h1C;
         4'd7:    off = 8'h20;
         4'd8:    off = 8'h24;
         default: off = 8'h3C;
      endcase
      return off;
   endfunction

endpackage

// ===== rtl/core/pbe_fsm.sv =====
// Scan sequencer: turns one request into up to two results and the next scan state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbe_fsm
   import pbe_pkg::*;
#(
   parameter int MAX_DEVICES = MAX_DEVICES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_fire,
   input  logic         in_user,
   input  logic [31:0]  in_data,
   output pbe_push_type push
);

   localparam int CNT_W = $clog2(MAX_DEVICES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEVICES);

   pbe_phase_type    phase_ff, phase_in;
   logic             host_multi_ff, host_multi_in;
   logic [2:0]       host_func_ff, host_func_in;
   logic [7:0]       cur_bus_ff, cur_bus_in;
   logic [4:0]       cur_slot_ff, cur_slot_in;
   logic [2:0]       cur_func_ff, cur_func_in;
   logic [3:0]       record_step_ff, record_step_in;
   logic             slot_multi_ff, slot_multi_in;
   logic [CNT_W-1:0] found_ff, found_in;

   function automatic pbe_result_type mk(input pbe_kind_type kind, input logic [7:0] bus,
                                         input logic [4:0] slot, input logic [2:0] func,
                                         input logic [7:0] off, input logic [31:0] word,
                                         input logic [5:0] idx);
      pbe_result_type r;
      r.kind = kind;
      r.bus_num = bus;
      r.slot_num = slot;
      r.func_num = func;
      r.reg_offset = off;
      r.word_value = word;
      r.device_index = idx;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic pbe_push_type add(input pbe_push_type p, input pbe_result_type r);
      pbe_push_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.first = r;
      end else begin
         q.second = r;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

   always_comb begin
      logic       do_func;
      logic       do_slot;
      logic       do_host;
      logic       do_finish;
      logic       do_bus;
      logic [7:0] bus_sel;
      logic [3:0] s;

      do_func = 1'b0;
      do_slot = 1'b0;
      do_host = 1'b0;
      do_finish = 1'b0;
      do_bus = 1'b0;
      bus_sel = 8'd0;
      s = (record_step_ff > REC_LAST) ? REC_LAST : record_step_ff;

      phase_in = phase_ff;
      host_multi_in = host_multi_ff;
      host_func_in = host_func_ff;
      cur_bus_in = cur_bus_ff;
      cur_slot_in = cur_slot_ff;
      cur_func_in = cur_func_ff;
      record_step_in = record_step_ff;
      slot_multi_in = slot_multi_ff;
      found_in = found_ff;
      push = '0;

      if (in_fire) begin
         if (!in_user) begin
            // A start request restarts the whole scan from the host bridge.
            host_multi_in = 1'b0;
            host_func_in = 3'd0;
            cur_bus_in = 8'd0;
            cur_slot_in = 5'd0;
            cur_func_in = 3'd0;
            record_step_in = 4'd0;
            slot_multi_in = 1'b0;
            found_in = '0;
            phase_in = PH_HOST_HDR;
            push = add(push, mk(KIND_READ, 8'd0, 5'd0, 3'd0, OFF_HEADER, 32'd0, 6'd0));
         end else begin
            case (phase_ff)
               PH_HOST_HDR: begin
                  host_multi_in = in_data[MULTI_BIT];
                  host_func_in = 3'd0;
                  if (in_data[MULTI_BIT]) begin
                     phase_in = PH_HOST_PROBE;
                     push = add(push, mk(KIND_READ, 8'd0, 5'd0, 3'd0, OFF_ID, 32'd0, 6'd0));
                  end else begin
                     do_bus = 1'b1;
                  end
               end
               PH_HOST_PROBE: begin
                  if (in_data[15:0] == VENDOR_NONE) begin
                     do_host = 1'b1;
                  end else begin
                     do_bus = 1'b1;
                     bus_sel = {5'd0, host_func_ff};
                  end
               end
               PH_FUNC_ID: begin
                  if (in_data[15:0] == VENDOR_NONE) begin
                     if (cur_func_ff == 3'd0) begin
                        do_slot = 1'b1;
                     end else begin
                        do_func = 1'b1;
                     end
                  end else if (found_ff >= CNT_MAX) begin
                     do_finish = 1'b1;
                  end else begin
                     // The ID probe is also the first captured dword of the record.
                     push = add(push, mk(KIND_DWORD, cur_bus_ff, cur_slot_ff, cur_func_ff,
                                         rec_offset(4'd0), in_data, 6'(found_ff)));
                     record_step_in = 4'd1;
                     phase_in = PH_RECORD;
                     push = add(push, mk(KIND_READ, cur_bus_ff, cur_slot_ff, cur_func_ff,
                                         rec_offset(4'd1), 32'd0, 6'd0));
                  end
               end
               PH_RECORD: begin
                  push = add(push, mk(KIND_DWORD, cur_bus_ff, cur_slot_ff, cur_func_ff,
                                      rec_offset(s), in_data, 6'(found_ff)));
                  if (s == 4'd2 && cur_func_ff == 3'd0) begin
                     slot_multi_in = in_data[MULTI_BIT];
                  end
                  if (s < REC_LAST) begin
                     record_step_in = s + 4'd1;
                     push = add(push, mk(KIND_READ, cur_bus_ff, cur_slot_ff, cur_func_ff,
                                         rec_offset(s + 4'd1), 32'd0, 6'd0));
                  end else begin
                     record_step_in = 4'd0;
                     found_in = found_ff + CNT_W'(1);
                     if (found_in >= CNT_MAX) begin
                        do_finish = 1'b1;
                     end else begin
                        do_func = 1'b1;
                     end
                  end
               end
               default: begin
                  // Read data with no scan running is dropped.
               end
            endcase
         end
      end

      // Advance through functions, slots and host functions in scan order.
      if (do_bus) begin
         cur_bus_in = bus_sel;
         cur_slot_in = 5'd0;
         cur_func_in = 3'd0;
         slot_multi_in = 1'b0;
         phase_in = PH_FUNC_ID;
         push = add(push, mk(KIND_READ, bus_sel, 5'd0, 3'd0, OFF_ID, 32'd0, 6'd0));
      end
      if (do_func) begin
         if (slot_multi_in && cur_func_in < FUNC_LAST) begin
            cur_func_in = cur_func_in + 3'd1;
            phase_in = PH_FUNC_ID;
            push = add(push, mk(KIND_READ, cur_bus_in, cur_slot_in, cur_func_in, OFF_ID,
                                32'd0, 6'd0));
         end else begin
            do_slot = 1'b1;
         end
      end
      if (do_slot) begin
         if (cur_slot_in < SLOT_LAST) begin
            cur_slot_in = cur_slot_in + 5'd1;
            cur_func_in = 3'd0;
            slot_multi_in = 1'b0;
            phase_in = PH_FUNC_ID;
            push = add(push, mk(KIND_READ, cur_bus_in, cur_slot_in, 3'd0, OFF_ID,
                                32'd0, 6'd0));
         end else begin
            do_host = 1'b1;
         end
      end
      if (do_host) begin
         if (host_multi_in && host_func_in < FUNC_LAST) begin
            host_func_in = host_func_in + 3'd1;
            phase_in = PH_HOST_PROBE;
            push = add(push, mk(KIND_READ, 8'd0, 5'd0, host_func_in, OFF_ID, 32'd0, 6'd0));
         end else begin
            do_finish = 1'b1;
         end
      end
      if (do_finish) begin
         phase_in = PH_IDLE;
         push = add(push, mk(KIND_DONE, 8'd0, 5'd0, 3'd0, 8'd0, 32'd0, 6'(found_in)));
      end

      if (push.count == 2'd1) begin
         push.first.last_of_run = 1'b1;
      end else if (push.count == 2'd2) begin
         push.second.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         host_multi_ff <= 1'b0;
         host_func_ff <= 3'd0;
         cur_bus_ff <= 8'd0;
         cur_slot_ff <= 5'd0;
         cur_func_ff <= 3'd0;
         record_step_ff <= 4'd0;
         slot_multi_ff <= 1'b0;
         found_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         host_multi_ff <= host_multi_in;
         host_func_ff <= host_func_in;
         cur_bus_ff <= cur_bus_in;
         cur_slot_ff <= cur_slot_in;
         cur_func_ff <= cur_func_in;
         record_step_ff <= record_step_in;
         slot_multi_ff <= slot_multi_in;
         found_ff <= found_in;
      end
   end

   `PBE_ASSERT(a_found_bound, clock, reset, found_ff <= CNT_MAX)
   `PBE_ASSERT_IMPL(a_record_step, clock, reset, phase_ff == PH_RECORD,
                    record_step_ff >= 4'd1 && record_step_ff <= REC_LAST)
   `PBE_ASSERT_IMPL(a_pair_order, clock, reset, in_fire && push.count == 2'd2,
                    push.first.kind == KIND_DWORD && push.second.last_of_run)

endmodule

// ===== rtl/core/pbe_rsp_fifo.sv =====
// Result queue: takes up to two results a cycle and delivers one a cycle while rd_ready is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbe_rsp_fifo
   import pbe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  pbe_push_type   push,
   output logic           room,
   output logic           rd_valid,
   input  logic           rd_ready,
   output pbe_result_type rd_data
);

   pbe_result_type        mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign pop = rd_valid && rd_ready;
   assign rd_valid = (count_ff != '0);
   assign rd_data = mem[rd_ptr_ff];
   // Room for two more results, whatever is popped this cycle.
   assign room = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + FIFO_PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `PBE_ASSERT(a_count_bound, clock, reset, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `PBE_ASSERT_IMPL(a_no_overflow, clock, reset, push.count != 2'd0,
                    ({1'b0, count_ff} + {2'b00, push.count}) <= 4'(FIFO_DEPTH))
   `PBE_ASSERT_NEXT(a_pop_only, clock, reset, pop && push.count == 2'd0,
                    count_ff == $past(count_ff) - FIFO_CNT_W'(1))

endmodule

// ===== rtl/core/pci_bus_enumeration_engine_top.sv =====
// Top level of the configuration-space bus enumeration engine.
`timescale 1ns / 1ps
// A start request (tuser 0) begins a walk of the PCI configuration space: the engine
// asks for the host bridge header, then for each bus, slot and function it needs,
// and every read completion returned on the request channel (tuser 1) during a scan
// yields one or two of the next read request, the captured dword of a present
// function and the final done result carrying the number of functions found. Each
// request is registered and then decided; its results, two at most, go into a
// four-entry queue in front of the result port, so a result passes the input
// register and then the queue. A request is taken every cycle as long as the queue
// has room for two results, so throughput is set by the result port, which delivers
// one result a cycle while rsp_tready is high.
module pci_bus_enumeration_engine_top
   import pbe_pkg::*;
#(
   parameter int MAX_DEVICES = MAX_DEVICES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // read_data
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bus_num, slot_num, func_num, reg_offset, word_value, device_index, zero pad
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // out_kind
   output logic        rsp_tlast    // last_of_run
);

   logic           in_valid_ff, in_valid_in;
   logic           in_user_ff;
   logic [31:0]    in_data_ff;
   logic           room;
   logic           fire;
   pbe_push_type   push;
   pbe_result_type rsp;

   assign fire = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_user_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   pbe_fsm #(
      .MAX_DEVICES(MAX_DEVICES)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .in_fire (fire),
      .in_user (in_user_ff),
      .in_data (in_data_ff),
      .push    (push)
   );

   pbe_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (rsp)
   );

   assign rsp_tdata = {2'b00, rsp.device_index, rsp.word_value, rsp.reg_offset,
                       rsp.func_num, rsp.slot_num, rsp.bus_num};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last_of_run;

endmodule

// ===== tb/pci_bus_enumeration_engine_top_tb.sv =====
// Self-checking testbench for the configuration-space bus enumeration engine.
`timescale 1ns / 1ps
module pci_bus_enumeration_engine_top_tb;
   import pbe_pkg::*;

   localparam int TABLE_SIZE = MAX_DEVICES_DEFAULT;
   localparam int RANDOM_REQUESTS = 1150;
   localparam int IDLE_PCT = 31;
   // Captured offsets by record step, step 0 in the lowest byte.
   localparam logic [79:0] CAPTURE_OFFS = {8'h3C, 8'h24, 8'h20, 8'h1C, 8'h18,
                                           8'h14, 8'h10, 8'h0C, 8'h08, 8'h00};

   typedef struct packed {
      logic           is_data;
      logic [31:0]    word;
      logic [1:0]     n_res;
      pbe_result_type res_first;
      pbe_result_type res_second;
   } scan_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // read_data
   logic        req_tuser = 1'b0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // bus_num, slot_num, func_num, reg_offset, word_value, device_index, zero pad
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;          // out_kind
   logic        rsp_tlast;          // last_of_run

   scan_request_type scan_requests[$];
   pbe_result_type   expected_results[$];
   int               accepted_count = 0;
   int               error_count = 0;
   logic             steady_window;

   // Scan state mirrored by the predictor.
   pbe_phase_type  scan_phase;
   logic           host_multi;
   logic [2:0]     host_func;
   logic [7:0]     cur_bus;
   logic [4:0]     cur_slot;
   logic [2:0]     cur_func;
   int             record_step;
   logic           slot_multi;
   int             found_count;
   int             res_n;
   pbe_result_type res_first;
   pbe_result_type res_second;

   pci_bus_enumeration_engine_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign steady_window = (accepted_count >= 350) && (accepted_count < 650);

   function automatic void add_result(pbe_kind_type k, logic [7:0] b, logic [4:0] s,
                                      logic [2:0] f, logic [7:0] o, logic [31:0] v,
                                      logic [5:0] idx);
      pbe_result_type r;
      r.kind = k;
      r.bus_num = b;
      r.slot_num = s;
      r.func_num = f;
      r.reg_offset = o;
      r.word_value = v;
      r.device_index = idx;
      r.last_of_run = 1'b0;
      if (res_n == 0) begin
         res_first = r;
      end else begin
         res_second = r;
      end
      res_n++;
   endfunction

   function automatic void end_scan();
      scan_phase = PH_IDLE;
      add_result(KIND_DONE, 8'd0, 5'd0, 3'd0, 8'd0, 32'd0, found_count[5:0]);
   endfunction

   function automatic void advance_host();
      if (host_multi && host_func < FUNC_LAST) begin
         host_func++;
         scan_phase = PH_HOST_PROBE;
         add_result(KIND_READ, 8'd0, 5'd0, host_func, OFF_ID, 32'd0, 6'd0);
      end else begin
         end_scan();
      end
   endfunction

   function automatic void advance_slot();
      if (cur_slot < SLOT_LAST) begin
         cur_slot++;
         cur_func = 3'd0;
         slot_multi = 1'b0;
         scan_phase = PH_FUNC_ID;
         add_result(KIND_READ, cur_bus, cur_slot, cur_func, OFF_ID, 32'd0, 6'd0);
      end else begin
         advance_host();
      end
   endfunction

   function automatic void advance_func();
      if (slot_multi && cur_func < FUNC_LAST) begin
         cur_func++;
         scan_phase = PH_FUNC_ID;
         add_result(KIND_READ, cur_bus, cur_slot, cur_func, OFF_ID, 32'd0, 6'd0);
      end else begin
         advance_slot();
      end
   endfunction

   function automatic void open_bus(logic [7:0] b);
      cur_bus = b;
      cur_slot = 5'd0;
      cur_func = 3'd0;
      slot_multi = 1'b0;
      scan_phase = PH_FUNC_ID;
      add_result(KIND_READ, cur_bus, cur_slot, cur_func, OFF_ID, 32'd0, 6'd0);
   endfunction

   // Works out the results of one request and advances the mirrored scan state.
   function automatic void walk_config_space(logic is_data, logic [31:0] word);
      res_n = 0;
      if (!is_data) begin
         host_multi = 1'b0;
         host_func = 3'd0;
         cur_bus = 8'd0;
         cur_slot = 5'd0;
         cur_func = 3'd0;
         record_step = 0;
         slot_multi = 1'b0;
         found_count = 0;
         scan_phase = PH_HOST_HDR;
         add_result(KIND_READ, 8'd0, 5'd0, 3'd0, OFF_HEADER, 32'd0, 6'd0);
      end else begin
         case (scan_phase)
            PH_HOST_HDR: begin
               host_multi = word[MULTI_BIT];
               host_func = 3'd0;
               if (host_multi) begin
                  scan_phase = PH_HOST_PROBE;
                  add_result(KIND_READ, 8'd0, 5'd0, 3'd0, OFF_ID, 32'd0, 6'd0);
               end else begin
                  open_bus(8'd0);
               end
            end
            PH_HOST_PROBE: begin
               if (word[15:0] == VENDOR_NONE) begin
                  advance_host();
               end else begin
                  open_bus({5'd0, host_func});
               end
            end
            PH_FUNC_ID: begin
               if (word[15:0] == VENDOR_NONE) begin
                  if (cur_func == 3'd0) begin
                     advance_slot();
                  end else begin
                     advance_func();
                  end
               end else if (found_count >= TABLE_SIZE) begin
                  end_scan();
               end else begin
                  // The vendor probe is also the first captured dword of the record.
                  add_result(KIND_DWORD, cur_bus, cur_slot, cur_func, CAPTURE_OFFS[7:0],
                             word, found_count[5:0]);
                  record_step = 1;
                  scan_phase = PH_RECORD;
                  add_result(KIND_READ, cur_bus, cur_slot, cur_func, CAPTURE_OFFS[15:8],
                             32'd0, 6'd0);
               end
            end
            PH_RECORD: begin
               add_result(KIND_DWORD, cur_bus, cur_slot, cur_func,
                          CAPTURE_OFFS[8*record_step +: 8], word, found_count[5:0]);
               if (record_step == 2 && cur_func == 3'd0) begin
                  slot_multi = word[MULTI_BIT];
               end
               if (record_step < REC_LAST) begin
                  record_step++;
                  add_result(KIND_READ, cur_bus, cur_slot, cur_func,
                             CAPTURE_OFFS[8*record_step +: 8], 32'd0, 6'd0);
               end else begin
                  record_step = 0;
                  found_count++;
                  if (found_count >= TABLE_SIZE) begin
                     end_scan();
                  end else begin
                     advance_func();
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (res_n == 1) begin
         res_first.last_of_run = 1'b1;
      end else if (res_n == 2) begin
         res_second.last_of_run = 1'b1;
      end
   endfunction

   // Predicts one request and appends it to the stimulus queue.
   function automatic void queue_request(logic is_data, logic [31:0] word);
      scan_request_type item;
      walk_config_space(is_data, word);
      item.is_data = is_data;
      item.word = word;
      item.n_res = res_n[1:0];
      item.res_first = res_first;
      item.res_second = res_second;
      scan_requests.push_back(item);
   endfunction

   // Random completion word: absent vendor with the given percent chance.
   function automatic logic [31:0] completion_word(int absent_pct);
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(99) < absent_pct) begin
         w[15:0] = VENDOR_NONE;
      end else if (w[15:0] == VENDOR_NONE) begin
         w[0] = 1'b0;
      end
      return w;
   endfunction

   initial begin
      int counted;
      int absent_pct;
      scan_phase = PH_IDLE;
      host_multi = 1'b0;
      host_func = 3'd0;
      cur_bus = 8'd0;
      cur_slot = 5'd0;
      cur_func = 3'd0;
      record_step = 0;
      slot_multi = 1'b0;
      found_count = 0;

      // Directed: completion while idle, multi-function host bridge, a full record
      // with the multi-function header bit, an absent function, a restart mid-scan
      // and a single-function host bridge.
      queue_request(1'b1, 32'hFFFF_FFFF);
      queue_request(1'b0, 32'h0000_0000);
      queue_request(1'b1, 32'h0080_0000);
      queue_request(1'b1, 32'h0000_0000);
      queue_request(1'b1, 32'h0000_0000);
      for (int i = 0; i < 9; i++) begin
         queue_request(1'b1, 32'hFFFF_FFFF);
      end
      queue_request(1'b1, 32'hFFFF_FFFF);
      queue_request(1'b0, 32'hFFFF_FFFF);
      queue_request(1'b1, 32'hFF7F_FFFF);
      queue_request(1'b1, 32'h0000_FFFF);
      queue_request(1'b1, 32'h1234_5678);

      // Random scans; the density of present functions varies from scan to scan.
      counted = 0;
      absent_pct = 50;
      while (counted < RANDOM_REQUESTS) begin
         if (scan_phase == PH_IDLE) begin
            if ($urandom_range(99) < 5) begin
               queue_request(1'b1, $urandom);
            end else begin
               case ($urandom_range(2))
                  0:       absent_pct = 40;
                  1:       absent_pct = 75;
                  default: absent_pct = 97;
               endcase
               queue_request(1'b0, $urandom);
               counted++;
            end
         end else if ($urandom_range(99) < 1) begin
            queue_request(1'b0, $urandom);
            counted++;
         end else begin
            queue_request(1'b1, completion_word(absent_pct));
            counted++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (scan_requests.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Request driver.
   always @(posedge clock) begin
      scan_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            item = scan_requests.pop_front();
            if (item.n_res >= 2'd1) begin
               expected_results.push_back(item.res_first);
            end
            if (item.n_res == 2'd2) begin
               expected_results.push_back(item.res_second);
            end
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            // The head of the queue is the request being presented.
            if (req_tvalid && req_tready) begin
               item = '0;
            end
            if (scan_requests.size() > 0 &&
                (steady_window || $urandom_range(99) >= IDLE_PCT)) begin
               item = scan_requests[0];
               req_tvalid <= 1'b1;
               req_tuser <= item.is_data;
               req_tdata <= item.word;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      pbe_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result with none expected: kind %0d tdata %h", rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser != want.kind) begin
                  $error("out_kind: expected %0d, actual %0d", want.kind, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[7:0] != want.bus_num) begin
                  $error("bus_num: expected %0d, actual %0d", want.bus_num, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tdata[12:8] != want.slot_num) begin
                  $error("slot_num: expected %0d, actual %0d", want.slot_num,
                         rsp_tdata[12:8]);
                  error_count++;
               end
               if (rsp_tdata[15:13] != want.func_num) begin
                  $error("func_num: expected %0d, actual %0d", want.func_num,
                         rsp_tdata[15:13]);
                  error_count++;
               end
               if (rsp_tdata[23:16] != want.reg_offset) begin
                  $error("reg_offset: expected %h, actual %h", want.reg_offset,
                         rsp_tdata[23:16]);
                  error_count++;
               end
               if (rsp_tdata[55:24] != want.word_value) begin
                  $error("word_value: expected %h, actual %h", want.word_value,
                         rsp_tdata[55:24]);
                  error_count++;
               end
               if (rsp_tdata[61:56] != want.device_index) begin
                  $error("device_index: expected %0d, actual %0d", want.device_index,
                         rsp_tdata[61:56]);
                  error_count++;
               end
               if (rsp_tlast != want.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                         rsp_tlast);
                  error_count++;
               end
            end
         end
         rsp_tready <= steady_window || ($urandom_range(99) >= IDLE_PCT);
      end
   end

endmodule
